>>> rtl/mmdp_pkg.sv
package mmdp_pkg;

    localparam int DEF_MAX_LEVELS     = 24;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_INDEX_BITS     = 24;

    localparam int LEVEL_BITS         = 5;
    localparam int COUNT_BITS         = 25;
    localparam int THRESH_BITS        = 16;
    localparam int CFG_ADDR_BITS      = 2;
    localparam int CFG_DATA_BITS      = 25;

    localparam logic [THRESH_BITS-1:0]   DEF_MIN_LEVEL_SIZE = THRESH_BITS'(800);

    localparam logic [CFG_ADDR_BITS-1:0] REG_SAMPLE_COUNT   = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_LEVEL_SIZE = CFG_ADDR_BITS'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CALC   = 5'b00010,
        S_FEED   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

endpackage

>>> rtl/min_max_decimation_pyramid.sv
// Min/max decimation pyramid for one channel. Each sample is pushed into level 0 and
// completed pairs cascade upward, one level per clock through a single compare unit,
// while the held result, if any, can move to the output. An input beat is accepted,
// each pair it completes is merged and emitted as the element moves up, the element is
// then stored in its free slot or dropped above levels_in_use, and the beat is closed
// out; an output stall holds any step that must move a result. A sample with final_req
// then scans every level, pairing leftovers with themselves and cascading them. Results
// are (level, index, min, max) tagged pairs in cascade order; last_of_run marks the final
// result caused by an input beat, which is why a result is held one step until the next
// one (or the end of the beat) is known.
// A write to sample_count or min_level_size while idle or recomputing recomputes the
// level count by repeated halving, one shift per cycle, during which in_ready is low.
module min_max_decimation_pyramid
    import mmdp_pkg::*;
#(
    parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [CFG_ADDR_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            final_req,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [LEVEL_BITS-1:0]           level,
    output logic [INDEX_BITS-1:0]           index,
    output logic signed [SAMPLE_BITS-1:0]   min_value,
    output logic signed [SAMPLE_BITS-1:0]   max_value,
    output logic                            last_of_run
);

    localparam int LVL_W = $clog2(MAX_LEVELS + 1);
    localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_LEVELS);
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

    // configuration
    logic [COUNT_BITS-1:0]   sample_count_reg;
    logic [THRESH_BITS-1:0]  min_level_size_reg;
    logic [COUNT_BITS-1:0]   calc_n_reg;
    logic [LVL_W-1:0]        calc_cnt_reg;
    logic [LVL_W-1:0]        levels_reg;

    // per-level state
    logic signed [SAMPLE_BITS-1:0] pend_lo_reg  [MAX_LEVELS];
    logic signed [SAMPLE_BITS-1:0] pend_hi_reg  [MAX_LEVELS];
    logic [INDEX_BITS-1:0]         pos_reg      [MAX_LEVELS];
    logic [MAX_LEVELS-1:0]         pend_vld_reg;

    // sequencer
    state_t                        state_reg, state_next;
    logic [LVL_W-1:0]              cur_lvl_reg, cur_lvl_next;
    logic [LVL_W-1:0]              scan_reg, scan_next;
    logic signed [SAMPLE_BITS-1:0] cur_lo_reg, cur_lo_next;
    logic signed [SAMPLE_BITS-1:0] cur_hi_reg, cur_hi_next;
    logic                          fin_reg, fin_next;
    logic                          flush_reg, flush_next;

    // held result and output register
    logic                          hold_vld_reg;
    logic [LEVEL_BITS-1:0]         hold_level_reg;
    logic [INDEX_BITS-1:0]         hold_index_reg;
    logic signed [SAMPLE_BITS-1:0] hold_lo_reg, hold_hi_reg;

    logic                          out_vld_reg;
    logic [LEVEL_BITS-1:0]         out_level_reg;
    logic [INDEX_BITS-1:0]         out_index_reg;
    logic signed [SAMPLE_BITS-1:0] out_lo_reg, out_hi_reg;
    logic                          out_last_reg;

    // datapath
    logic [IDX_W-1:0]              op_idx;
    logic signed [SAMPLE_BITS-1:0] rd_lo, rd_hi, mrg_lo, mrg_hi, em_lo, em_hi;
    logic [LVL_W-1:0]              em_lvl;
    logic                          rd_vld;
    logic                          out_free, emit_ok;
    logic                          do_store, do_emit, clr_all, clr_above;
    logic                          out_load, out_last_load, hold_drop;
    logic                          accept, calc_go;
    logic [LVL_W-1:0]              levels_new;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !cfg_write;

    assign op_idx = (state_reg == S_SCAN) ? scan_reg[IDX_W-1:0] : cur_lvl_reg[IDX_W-1:0];
    assign rd_lo  = pend_lo_reg[op_idx];
    assign rd_hi  = pend_hi_reg[op_idx];
    assign rd_vld = pend_vld_reg[op_idx];

    assign mrg_lo = (rd_lo < cur_lo_reg) ? rd_lo : cur_lo_reg;
    assign mrg_hi = (rd_hi > cur_hi_reg) ? rd_hi : cur_hi_reg;

    assign em_lo  = (state_reg == S_SCAN) ? rd_lo : mrg_lo;
    assign em_hi  = (state_reg == S_SCAN) ? rd_hi : mrg_hi;
    assign em_lvl = (state_reg == S_SCAN) ? scan_reg : cur_lvl_reg;

    assign out_free = !out_vld_reg || out_ready;
    // a new result pushes the held one out, which needs the output slot
    assign emit_ok  = !hold_vld_reg || out_free;

    assign calc_go    = cfg_write && ((cfg_index == REG_SAMPLE_COUNT) ||
                                      (cfg_index == REG_MIN_LEVEL_SIZE));
    assign levels_new = (calc_cnt_reg == '0) ? LVL_ONE : calc_cnt_reg;

    always_comb
    begin
        state_next    = state_reg;
        cur_lvl_next  = cur_lvl_reg;
        scan_next     = scan_reg;
        cur_lo_next   = cur_lo_reg;
        cur_hi_next   = cur_hi_reg;
        fin_next      = fin_reg;
        flush_next    = flush_reg;
        do_store      = 1'b0;
        do_emit       = 1'b0;
        clr_all       = 1'b0;
        clr_above     = 1'b0;
        out_load      = 1'b0;
        out_last_load = 1'b0;
        hold_drop     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_lvl_next = '0;
                    cur_lo_next  = sample;
                    cur_hi_next  = sample;
                    fin_next     = final_req;
                    flush_next   = 1'b0;
                    state_next   = S_FEED;
                end
            end
            S_CALC:
            begin
                if ((calc_n_reg > COUNT_BITS'(min_level_size_reg)) && (calc_cnt_reg < LVL_MAX))
                begin
                    // shift and count handled in the register block
                end
                else
                begin
                    clr_above  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FEED:
            begin
                if ((cur_lvl_reg < levels_reg) && !rd_vld)
                begin
                    do_store = 1'b1;
                end
                if ((cur_lvl_reg < levels_reg) && rd_vld)
                begin
                    if (emit_ok)
                    begin
                        do_emit      = 1'b1;
                        out_load     = hold_vld_reg;
                        cur_lo_next  = mrg_lo;
                        cur_hi_next  = mrg_hi;
                        cur_lvl_next = cur_lvl_reg + LVL_ONE;
                    end
                end
                else
                begin
                    // cascade is over for this element
                    if (flush_reg)
                    begin
                        scan_next  = scan_reg + LVL_ONE;
                        state_next = S_SCAN;
                    end
                    else if (fin_reg)
                    begin
                        scan_next  = '0;
                        flush_next = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg >= levels_reg)
                begin
                    clr_all    = 1'b1;
                    state_next = S_FINISH;
                end
                else if (rd_vld)
                begin
                    // leftover pairs with itself, then moves up
                    if (emit_ok)
                    begin
                        do_emit      = 1'b1;
                        out_load     = hold_vld_reg;
                        cur_lo_next  = rd_lo;
                        cur_hi_next  = rd_hi;
                        cur_lvl_next = scan_reg + LVL_ONE;
                        state_next   = S_FEED;
                    end
                end
                else
                begin
                    scan_next = scan_reg + LVL_ONE;
                end
            end
            S_FINISH:
            begin
                if (!hold_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_load = 1'b1;
                    hold_drop     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (calc_go && ((state_reg == S_IDLE) || (state_reg == S_CALC)))
        begin
            clr_above  = 1'b0;
            state_next = S_CALC;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            sample_count_reg   <= '0;
            min_level_size_reg <= DEF_MIN_LEVEL_SIZE;
            levels_reg         <= LVL_ONE;
            calc_n_reg         <= '0;
            calc_cnt_reg       <= '0;
            cur_lvl_reg        <= '0;
            scan_reg           <= '0;
            fin_reg            <= 1'b0;
            flush_reg          <= 1'b0;
            hold_vld_reg       <= 1'b0;
            out_vld_reg        <= 1'b0;
            pend_vld_reg       <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cur_lvl_reg <= cur_lvl_next;
            scan_reg    <= scan_next;
            fin_reg     <= fin_next;
            flush_reg   <= flush_next;

            if (cfg_write && (cfg_index == REG_SAMPLE_COUNT))
            begin
                sample_count_reg <= cfg_data[COUNT_BITS-1:0];
            end
            if (cfg_write && (cfg_index == REG_MIN_LEVEL_SIZE))
            begin
                min_level_size_reg <= cfg_data[THRESH_BITS-1:0];
            end

            if (calc_go)
            begin
                calc_n_reg   <= (cfg_index == REG_SAMPLE_COUNT) ? cfg_data[COUNT_BITS-1:0]
                                                                 : sample_count_reg;
                calc_cnt_reg <= '0;
            end
            else if (state_reg == S_CALC)
            begin
                calc_n_reg   <= calc_n_reg >> 1;
                calc_cnt_reg <= calc_cnt_reg + LVL_ONE;
            end

            if (clr_above)
            begin
                levels_reg <= levels_new;
                for (int i = 0; i < MAX_LEVELS; i++)
                begin
                    if (LVL_W'(i) >= levels_new)
                    begin
                        pend_vld_reg[i] <= 1'b0;
                    end
                end
            end

            if (do_store)
            begin
                pend_vld_reg[op_idx] <= 1'b1;
            end
            if (do_emit)
            begin
                pend_vld_reg[op_idx] <= 1'b0;
                pos_reg[op_idx]      <= pos_reg[op_idx] + INDEX_BITS'(1);
            end
            if (clr_all)
            begin
                pend_vld_reg <= '0;
                for (int i = 0; i < MAX_LEVELS; i++)
                begin
                    pos_reg[i] <= '0;
                end
            end

            if (do_emit)
            begin
                hold_vld_reg <= 1'b1;
            end
            else if (hold_drop)
            begin
                hold_vld_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_lo_reg <= cur_lo_next;
        cur_hi_reg <= cur_hi_next;

        if (do_store)
        begin
            pend_lo_reg[op_idx] <= cur_lo_reg;
            pend_hi_reg[op_idx] <= cur_hi_reg;
        end

        if (out_load)
        begin
            out_level_reg <= hold_level_reg;
            out_index_reg <= hold_index_reg;
            out_lo_reg    <= hold_lo_reg;
            out_hi_reg    <= hold_hi_reg;
            out_last_reg  <= out_last_load;
        end

        if (do_emit)
        begin
            hold_level_reg <= LEVEL_BITS'(em_lvl);
            hold_index_reg <= pos_reg[op_idx];
            hold_lo_reg    <= em_lo;
            hold_hi_reg    <= em_hi;
        end
    end

    assign out_valid   = out_vld_reg;
    assign level       = out_level_reg;
    assign index       = out_index_reg;
    assign min_value   = out_lo_reg;
    assign max_value   = out_hi_reg;
    assign last_of_run = out_last_reg;

endmodule
